[rtl/lsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

    // field and arithmetic widths
    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CELL_W     = 31;
    localparam int CFG_W      = 31;

    // divider: 50-bit numerator, 33-bit divisor, 32 quotient bits plus overflow
    localparam int DIV_NUM_W  = 50;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_Q_W    = 32;
    localparam int DIV_HI_W   = DIV_NUM_W - DIV_Q_W;

    // square root: 64-bit radicand, 32-bit root
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;

    // register stages inside each unit
    localparam int DIV_STAGES  = DIV_Q_W;
    localparam int SQRT_STAGES = SQRT_OUT_W;

    // register reset values
    localparam logic [CFG_W-1:0] MAX_CURV_RESET   = 31'd67108864;
    localparam logic [CFG_W-1:0] GRAD_FLOOR_RESET = 31'd1;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAX_CURVATURE  = 1'b0,
        CFG_GRADIENT_FLOOR = 1'b1
    } cfg_idx_t;

endpackage

`default_nettype wire

[rtl/lsc_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsc_div import lsc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic      [DIV_Q_W-1:0]   quo,
    output logic                      ovf
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0]   low_reg [DIV_STAGES];
    logic [DIV_DEN_W-1:0] den_reg [DIV_STAGES];
    logic [DIV_Q_W-1:0]   quo_reg [DIV_STAGES];
    logic                 ovf_reg [DIV_STAGES];

    // quotient overflow when the top part already reaches the divisor
    logic [DIV_HI_W-1:0] num_hi;
    logic                ovf_first;
    assign num_hi    = num[DIV_NUM_W-1:DIV_Q_W];
    assign ovf_first = {{(DIV_DEN_W-DIV_HI_W){1'b0}}, num_hi} >= den;

    // one restoring step per stage, one quotient bit each
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_Q_W-1:0]   low_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_Q_W-1:0]   quo_in;
        logic                 ovf_in;
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W:0]   diff;
        logic                 ge;

        if (g == 0) begin : g_first
            assign rem_in = {{(DIV_DEN_W-DIV_HI_W){1'b0}}, num_hi};
            assign low_in = num[DIV_Q_W-1:0];
            assign den_in = den;
            assign quo_in = '0;
            assign ovf_in = ovf_first;
        end else begin : g_next
            assign rem_in = rem_reg[g-1];
            assign low_in = low_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign ovf_in = ovf_reg[g-1];
        end

        assign trial = {rem_in, low_in[DIV_Q_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
                low_reg[g] <= {low_in[DIV_Q_W-2:0], 1'b0};
                den_reg[g] <= den_in;
                quo_reg[g] <= {quo_in[DIV_Q_W-2:0], ge};
                ovf_reg[g] <= ovf_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
    assign ovf = ovf_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/lsc_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsc_sqrt import lsc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [SQRT_IN_W-1:0]  rad,
    output logic      [SQRT_OUT_W-1:0] root
);

    localparam int REM_W = SQRT_OUT_W + 2;

    logic [REM_W-1:0]      rem_reg  [SQRT_STAGES];
    logic [SQRT_IN_W-1:0]  rad_reg  [SQRT_STAGES];
    logic [SQRT_OUT_W-1:0] root_reg [SQRT_STAGES];

    // digit-by-digit root, two radicand bits per stage
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
        logic [REM_W-1:0]      rem_in;
        logic [SQRT_IN_W-1:0]  rad_in;
        logic [SQRT_OUT_W-1:0] root_in;
        logic [REM_W+1:0]      cur;
        logic [REM_W+1:0]      trial;
        logic [REM_W+1:0]      diff;
        logic                  ge;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign rad_in  = rad_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        assign cur   = {rem_in, rad_in[SQRT_IN_W-1:SQRT_IN_W-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
                rad_reg[g]  <= {rad_in[SQRT_IN_W-3:0], 2'b00};
                root_reg[g] <= {root_in[SQRT_OUT_W-2:0], ge};
            end
        end
    end

    assign root = root_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

[rtl/level_set_curvature.sv]
`timescale 1ns / 1ps
`default_nettype none

// Mean curvature of a 2D level set from a 3x3 stencil, Q16.16 throughout.
// Fully pipelined: one stencil per cycle sustained while the result side
// is not stalling. The depth comes from the chain of bit-per-stage
// units: first divisions, second divisions in parallel with the 32-stage
// square root of the squared gradient, the normal divisions, the product,
// term and sum stages, and the final division by the gradient magnitude.
// A stalled output holds the pipeline; bubbles ahead of a waiting result
// are still squeezed out. Configuration writes are taken
// at any time but are meant for an idle block; the curvature limit is read
// at the output stage and gradient_floor just after the square root.
module level_set_curvature import lsc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // phi_center, phi_left, phi_right, phi_down, phi_up, phi_up_right,
    // phi_down_right, phi_up_left, phi_down_left, cell_width, cell_height
    input  wire logic [351:0]        s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // curvature_out
    output logic [DATA_W-1:0]        m_tdata,
    // flat_gradient, saturated
    output logic [1:0]               m_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int DEPTH = 136;

    // saturate a quotient to the signed data range
    function automatic logic [DATA_W-1:0] sat_q(input logic neg, input logic of,
                                                input logic [DIV_Q_W-1:0] q);
        logic [DATA_W-1:0] r;
        if (neg) begin
            if (of || q > 32'h8000_0000) r = 32'h8000_0000;
            else                         r = ~q + 32'd1;
        end else begin
            if (of || q > 32'h7fff_ffff) r = 32'h7fff_ffff;
            else                         r = q;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? ~v + 32'd1 : v;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] max_curv_reg;
    logic [CFG_W-1:0] grad_floor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_curv_reg   <= MAX_CURV_RESET;
            grad_floor_reg <= GRAD_FLOOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_CURVATURE:  max_curv_reg   <= cfg_data;
                CFG_GRADIENT_FLOOR: grad_floor_reg <= cfg_data;
            endcase
        end
    end

    // pipeline advance and output register load
    logic adv;
    logic out_ld;
    logic vld_reg [DEPTH];

    assign out_ld   = !m_tvalid || m_tready;
    assign adv      = out_ld || !vld_reg[DEPTH-1];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 1: stencil differences
    logic [DATA_W-1:0] pc, pl, pr, pd, pu, pur, pdr, pul, pdl;
    logic [CELL_W-1:0] cw, ch;
    assign pc  = s_tdata[31:0];
    assign pl  = s_tdata[63:32];
    assign pr  = s_tdata[95:64];
    assign pd  = s_tdata[127:96];
    assign pu  = s_tdata[159:128];
    assign pur = s_tdata[191:160];
    assign pdr = s_tdata[223:192];
    assign pul = s_tdata[255:224];
    assign pdl = s_tdata[287:256];
    assign cw  = s_tdata[318:288];
    assign ch  = s_tdata[349:319];

    logic [32:0]       dx_reg, dy_reg;
    logic [33:0]       dxx_reg, dyy_reg, dxy_reg;
    logic [CELL_W-1:0] w_reg, h_reg;
    logic              pcpos_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg    <= {pr[31], pr} - {pl[31], pl};
            dy_reg    <= {pu[31], pu} - {pd[31], pd};
            dxx_reg   <= {{2{pr[31]}}, pr} + {{2{pl[31]}}, pl} - {pc[31], pc, 1'b0};
            dyy_reg   <= {{2{pu[31]}}, pu} + {{2{pd[31]}}, pd} - {pc[31], pc, 1'b0};
            dxy_reg   <= {{2{pur[31]}}, pur} - {{2{pdr[31]}}, pdr}
                       - {{2{pul[31]}}, pul} + {{2{pdl[31]}}, pdl};
            w_reg     <= (cw == '0) ? 31'd1 : cw;
            h_reg     <= (ch == '0) ? 31'd1 : ch;
            pcpos_reg <= !pc[31] && (pc != '0);
        end
    end

    // first divisions: phix, phiy and the inner part of the second differences
    logic [32:0] dx_mag, dy_mag;
    logic [33:0] dxx_mag, dyy_mag, dxy_mag;
    assign dx_mag  = dx_reg[32]  ? ~dx_reg  + 33'd1 : dx_reg;
    assign dy_mag  = dy_reg[32]  ? ~dy_reg  + 33'd1 : dy_reg;
    assign dxx_mag = dxx_reg[33] ? ~dxx_reg + 34'd1 : dxx_reg;
    assign dyy_mag = dyy_reg[33] ? ~dyy_reg + 34'd1 : dyy_reg;
    assign dxy_mag = dxy_reg[33] ? ~dxy_reg + 34'd1 : dxy_reg;

    logic [DIV_Q_W-1:0] q1 [5];
    logic               o1 [5];

    lsc_div u_div_x (.aclk, .en(adv), .num({1'b0, dx_mag, 16'b0}),
        .den({1'b0, w_reg, 1'b0}), .quo(q1[0]), .ovf(o1[0]));
    lsc_div u_div_y (.aclk, .en(adv), .num({1'b0, dy_mag, 16'b0}),
        .den({1'b0, h_reg, 1'b0}), .quo(q1[1]), .ovf(o1[1]));
    lsc_div u_div_xx1 (.aclk, .en(adv), .num({dxx_mag, 16'b0}),
        .den({2'b0, w_reg}), .quo(q1[2]), .ovf(o1[2]));
    lsc_div u_div_yy1 (.aclk, .en(adv), .num({dyy_mag, 16'b0}),
        .den({2'b0, h_reg}), .quo(q1[3]), .ovf(o1[3]));
    lsc_div u_div_xy1 (.aclk, .en(adv), .num({dxy_mag, 16'b0}),
        .den({w_reg, 2'b0}), .quo(q1[4]), .ovf(o1[4]));

    // side data alongside the first divisions
    logic [4:0]          sg1_dly [DIV_STAGES];
    logic [2*CELL_W-1:0] wh_dly  [DIV_STAGES+1];
    always_ff @(posedge aclk) begin
        if (adv) begin
            sg1_dly[0] <= {dx_reg[32], dy_reg[32], dxx_reg[33], dyy_reg[33], dxy_reg[33]};
            for (int i = 1; i < DIV_STAGES; i++) sg1_dly[i] <= sg1_dly[i-1];
            wh_dly[0] <= {w_reg, h_reg};
            for (int i = 1; i < DIV_STAGES + 1; i++) wh_dly[i] <= wh_dly[i-1];
        end
    end

    logic [4:0] sg1;
    assign sg1 = sg1_dly[DIV_STAGES-1];

    // stage 34: saturated first quotients
    logic [DATA_W-1:0] phix_reg, phiy_reg, xx1_reg, yy1_reg, xy1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            phix_reg <= sat_q(sg1[4], o1[0], q1[0]);
            phiy_reg <= sat_q(sg1[3], o1[1], q1[1]);
            xx1_reg  <= sat_q(sg1[2], o1[2], q1[2]);
            yy1_reg  <= sat_q(sg1[1], o1[3], q1[3]);
            xy1_reg  <= sat_q(sg1[0], o1[4], q1[4]);
        end
    end

    logic [CELL_W-1:0] w_b, h_b;
    assign w_b = wh_dly[DIV_STAGES][2*CELL_W-1:CELL_W];
    assign h_b = wh_dly[DIV_STAGES][CELL_W-1:0];

    // second divisions: phixx, phiyy, phixy
    logic [DIV_Q_W-1:0] q2 [3];
    logic               o2 [3];

    lsc_div u_div_xx2 (.aclk, .en(adv), .num({2'b0, mag32(xx1_reg), 16'b0}),
        .den({2'b0, w_b}), .quo(q2[0]), .ovf(o2[0]));
    lsc_div u_div_yy2 (.aclk, .en(adv), .num({2'b0, mag32(yy1_reg), 16'b0}),
        .den({2'b0, h_b}), .quo(q2[1]), .ovf(o2[1]));
    lsc_div u_div_xy2 (.aclk, .en(adv), .num({2'b0, mag32(xy1_reg), 16'b0}),
        .den({2'b0, h_b}), .quo(q2[2]), .ovf(o2[2]));

    logic [2:0]          sg2_dly [DIV_STAGES];
    logic [2*DATA_W-1:0] pxy_dly [DIV_STAGES+2];
    always_ff @(posedge aclk) begin
        if (adv) begin
            sg2_dly[0] <= {xx1_reg[31], yy1_reg[31], xy1_reg[31]};
            for (int i = 1; i < DIV_STAGES; i++) sg2_dly[i] <= sg2_dly[i-1];
            pxy_dly[0] <= {phix_reg, phiy_reg};
            for (int i = 1; i < DIV_STAGES + 2; i++) pxy_dly[i] <= pxy_dly[i-1];
        end
    end

    logic [2:0] sg2;
    assign sg2 = sg2_dly[DIV_STAGES-1];

    // stage 67: second differences
    logic [DATA_W-1:0] phixx_reg, phiyy_reg, phixy_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            phixx_reg <= sat_q(sg2[2], o2[0], q2[0]);
            phiyy_reg <= sat_q(sg2[1], o2[1], q2[1]);
            phixy_reg <= sat_q(sg2[0], o2[2], q2[2]);
        end
    end

    // squared gradient and its root
    logic [2*DATA_W-1:0] sqx_reg, sqy_reg, sqs_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg <= mag32(phix_reg) * mag32(phix_reg);
            sqy_reg <= mag32(phiy_reg) * mag32(phiy_reg);
            sqs_reg <= sqx_reg + sqy_reg;
        end
    end

    logic [SQRT_OUT_W-1:0] gm;
    lsc_sqrt u_sqrt (.aclk, .en(adv), .rad(sqs_reg), .root(gm));

    logic [DATA_W-1:0] phix_d, phiy_d;
    assign phix_d = pxy_dly[DIV_STAGES+1][2*DATA_W-1:DATA_W];
    assign phiy_d = pxy_dly[DIV_STAGES+1][DATA_W-1:0];

    // unit normal divisions
    logic [DIV_Q_W-1:0] qn [2];
    logic               on [2];

    lsc_div u_div_nx (.aclk, .en(adv), .num({2'b0, mag32(phix_d), 16'b0}),
        .den({1'b0, gm}), .quo(qn[0]), .ovf(on[0]));
    lsc_div u_div_ny (.aclk, .en(adv), .num({2'b0, mag32(phiy_d), 16'b0}),
        .den({1'b0, gm}), .quo(qn[1]), .ovf(on[1]));

    // flat test and side data alongside the normal divisions
    logic                  flat_dly [68];
    logic [1:0]            sgn_dly  [DIV_STAGES];
    logic [SQRT_OUT_W-1:0] gm_dly   [DIV_STAGES+4];
    logic [3*DATA_W-1:0]   d2_dly   [35];
    always_ff @(posedge aclk) begin
        if (adv) begin
            flat_dly[0] <= (gm == '0) || (gm < {1'b0, grad_floor_reg});
            for (int i = 1; i < 68; i++) flat_dly[i] <= flat_dly[i-1];
            sgn_dly[0] <= {phix_d[31], phiy_d[31]};
            for (int i = 1; i < DIV_STAGES; i++) sgn_dly[i] <= sgn_dly[i-1];
            gm_dly[0] <= gm;
            for (int i = 1; i < DIV_STAGES + 4; i++) gm_dly[i] <= gm_dly[i-1];
            d2_dly[0] <= {phixx_reg, phiyy_reg, phixy_reg};
            for (int i = 1; i < 35; i++) d2_dly[i] <= d2_dly[i-1];
        end
    end

    // stage 101: normal components, at most one in magnitude when not flat
    logic [DATA_W-1:0] nx_reg, ny_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg <= sat_q(sgn_dly[DIV_STAGES-1][1], on[0], qn[0]);
            ny_reg <= sat_q(sgn_dly[DIV_STAGES-1][0], on[1], qn[1]);
        end
    end

    // stage 102: normal products
    logic [DATA_W-1:0] nx_abs, ny_abs;
    logic [16:0] nx_mag, ny_mag;
    logic [33:0] pxx, pxy, pyy;
    assign nx_abs = mag32(nx_reg);
    assign ny_abs = mag32(ny_reg);
    assign nx_mag = nx_abs[16:0];
    assign ny_mag = ny_abs[16:0];
    assign pxx    = nx_mag * nx_mag;
    assign pxy    = nx_mag * ny_mag;
    assign pyy    = ny_mag * ny_mag;

    logic [17:0] nxx_reg, nxy_reg, nyy_reg;
    logic        nxy_neg_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            nxx_reg     <= pxx[33:16];
            nxy_reg     <= pxy[33:16];
            nyy_reg     <= pyy[33:16];
            nxy_neg_reg <= nx_reg[31] ^ ny_reg[31];
        end
    end

    // stage 103: curvature terms
    logic [DATA_W-1:0] phixx_d, phiyy_d, phixy_d;
    assign phixx_d = d2_dly[34][3*DATA_W-1:2*DATA_W];
    assign phiyy_d = d2_dly[34][2*DATA_W-1:DATA_W];
    assign phixy_d = d2_dly[34][DATA_W-1:0];

    logic [49:0] p1, p3;
    logic [50:0] p2;
    assign p1 = nxx_reg * mag32(phiyy_d);
    assign p2 = {nxy_reg, 1'b0} * mag32(phixy_d);
    assign p3 = nyy_reg * mag32(phixx_d);

    logic [36:0] t1_reg, t2_reg, t3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg <= phiyy_d[31] ? ~{3'b0, p1[49:16]} + 37'd1 : {3'b0, p1[49:16]};
            t2_reg <= (nxy_neg_reg ^ phixy_d[31]) ? ~{2'b0, p2[50:16]} + 37'd1
                                                  : {2'b0, p2[50:16]};
            t3_reg <= phixx_d[31] ? ~{3'b0, p3[49:16]} + 37'd1 : {3'b0, p3[49:16]};
        end
    end

    // stage 104: numerator sum
    logic [36:0] s_reg;
    always_ff @(posedge aclk) begin
        if (adv) s_reg <= t1_reg - t2_reg + t3_reg;
    end

    logic [36:0] s_mag;
    logic        s_pos;
    assign s_mag = s_reg[36] ? ~s_reg + 37'd1 : s_reg;
    assign s_pos = !s_reg[36] && (s_reg != '0);

    // final division by the magnitude
    logic [DIV_Q_W-1:0] qk;
    logic               ok;
    lsc_div u_div_k (.aclk, .en(adv), .num({s_mag[33:0], 16'b0}),
        .den({1'b0, gm_dly[DIV_STAGES+3]}), .quo(qk), .ovf(ok));

    logic spos_dly  [DIV_STAGES];
    logic pcpos_dly [135];
    always_ff @(posedge aclk) begin
        if (adv) begin
            spos_dly[0] <= s_pos;
            for (int i = 1; i < DIV_STAGES; i++) spos_dly[i] <= spos_dly[i-1];
            pcpos_dly[0] <= pcpos_reg;
            for (int i = 1; i < 135; i++) pcpos_dly[i] <= pcpos_dly[i-1];
        end
    end

    // result selection and limiting
    logic              flat_f, sat_f, neg_f;
    logic [CFG_W-1:0]  km;
    logic [DATA_W-1:0] curv;
    always_comb begin
        flat_f = flat_dly[67];
        sat_f  = 1'b0;
        if (flat_f) begin
            km    = max_curv_reg;
            neg_f = !pcpos_dly[134];
        end else begin
            neg_f = spos_dly[DIV_STAGES-1];
            if (ok || qk > {1'b0, max_curv_reg}) begin
                km    = max_curv_reg;
                sat_f = 1'b1;
            end else begin
                km = qk[CFG_W-1:0];
            end
        end
        curv = neg_f ? ~{1'b0, km} + 32'd1 : {1'b0, km};
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_ld) begin
            m_tvalid <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            m_tdata <= curv;
            m_tuser <= {sat_f, flat_f};
        end
    end

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("flat and saturated both set");

    a_flat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata == {1'b0, max_curv_reg} || m_tdata == ~{1'b0, max_curv_reg} + 32'd1))
        else $error("flat result is not plus or minus the limit");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && vld_reg[DEPTH-1]))
        else $error("input held off without a blocked result");

    a_stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg[DEPTH-1]) && vld_reg[DEPTH-1])
        else $error("pipeline tail moved during a stall");
`endif

endmodule

`default_nettype wire

[sim/lsc_checker.sv]
`timescale 1ns / 1ps

module lsc_checker import lsc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [351:0]      s_tdata,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [DATA_W-1:0] m_tdata,
    input  wire logic [1:0]        m_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     curv_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] curvature;
        logic              flat;
        logic              sat;
    } curv_result_t;

    curv_result_t curv_queue[$];
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] floor_reg;

    function automatic logic [63:0] mag(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint clip(bit neg, logic [63:0] m);
        if (neg) begin
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            return -longint'(m);
        end
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        return longint'(m);
    endfunction

    // fixed-point divide toward zero, clipped to the 32-bit range
    function automatic longint fx_div(longint x, logic [63:0] den);
        logic [63:0] q;
        q = (mag(x) << FRAC_BITS) / den;
        return clip(x < 0, q);
    endfunction

    // fixed-point multiply toward zero, with 64-bit wraparound
    function automatic longint fx_mul(longint a, longint b);
        logic [63:0] p;
        p = (mag(a) * mag(b)) >> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic curv_result_t predict_curvature(logic [351:0] d);
        longint pc, pl, pr, pd, pu, pur, pdr, pul, pdl;
        longint phix, phiy, phixx, phiyy, phixy, nx, ny, t1, t2, t3, s;
        logic [63:0] w, h, gm, km;
        bit flat, sat, neg;
        curv_result_t r;
        pc  = longint'($signed(d[31:0]));
        pl  = longint'($signed(d[63:32]));
        pr  = longint'($signed(d[95:64]));
        pd  = longint'($signed(d[127:96]));
        pu  = longint'($signed(d[159:128]));
        pur = longint'($signed(d[191:160]));
        pdr = longint'($signed(d[223:192]));
        pul = longint'($signed(d[255:224]));
        pdl = longint'($signed(d[287:256]));
        w = {33'b0, d[318:288]};
        h = {33'b0, d[349:319]};
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        sat = 0;

        // central differences
        phix  = fx_div(pr - pl, 2 * w);
        phiy  = fx_div(pu - pd, 2 * h);
        phixx = fx_div(fx_div(pr - 2 * pc + pl, w), w);
        phiyy = fx_div(fx_div(pu - 2 * pc + pd, h), h);
        phixy = fx_div(fx_div(pur - pdr - pul + pdl, 4 * w), h);

        gm = int_sqrt(mag(phix) * mag(phix) + mag(phiy) * mag(phiy));
        flat = (gm == 0) || (gm < {33'b0, floor_reg});

        if (flat) begin
            km = {33'b0, limit_reg};
            neg = !(pc > 0);
        end else begin
            // curvature through the unit normal
            nx = fx_div(phix, gm);
            ny = fx_div(phiy, gm);
            t1 = fx_mul(fx_mul(nx, nx), phiyy);
            t2 = fx_mul(2 * fx_mul(nx, ny), phixy);
            t3 = fx_mul(fx_mul(ny, ny), phixx);
            s = t1 - t2 + t3;
            km = (mag(s) << FRAC_BITS) / gm;
            neg = s > 0;
            if (km > {33'b0, limit_reg}) begin
                km = {33'b0, limit_reg};
                sat = 1;
            end
        end
        r.curvature = neg ? 32'(-km) : 32'(km);
        r.flat = flat;
        r.sat = sat;
        return r;
    endfunction

    assign curv_pending = curv_queue.size();

    // registers, predictions and comparison
    always @(posedge aclk) begin
        curv_result_t exp_r;
        int errs;
        errs = 0;
        if (!aresetn) begin
            limit_reg <= MAX_CURV_RESET;
            floor_reg <= GRAD_FLOOR_RESET;
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MAX_CURVATURE) limit_reg <= cfg_data;
                else if (cfg_index == CFG_GRADIENT_FLOOR) floor_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) curv_queue.push_back(predict_curvature(s_tdata));
            if (m_tvalid && m_tready) begin
                if (curv_queue.size() == 0) begin
                    $error("result word with no prediction: curvature_out %h", m_tdata);
                    errs++;
                end else begin
                    exp_r = curv_queue.pop_front();
                    if (m_tdata !== exp_r.curvature) begin
                        $error("curvature_out expected %h actual %h", exp_r.curvature, m_tdata);
                        errs++;
                    end
                    if (m_tuser[0] !== exp_r.flat) begin
                        $error("flat_gradient expected %b actual %b", exp_r.flat, m_tuser[0]);
                        errs++;
                    end
                    if (m_tuser[1] !== exp_r.sat) begin
                        $error("saturated expected %b actual %b", exp_r.sat, m_tuser[1]);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lsc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic [351:0]      s_tdata = '0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    int fail_count;
    int curv_pending;
    int words_sent = 0;
    int cycle_count = 0;
    int rx_wait = 0;
    bit long_hold = 0;
    bit no_idle = 0;

    level_set_curvature DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lsc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .curv_pending(curv_pending)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            m_tready <= 0;
            rx_wait <= 0;
        end else if (long_hold) begin
            m_tready <= 0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else if (m_tready && m_tvalid) begin
            g = no_idle ? 0 : $urandom_range(0, 8);
            rx_wait <= g;
            m_tready <= (g == 0);
        end else begin
            m_tready <= 1;
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial begin
        wait (words_sent >= 560);
        @(posedge aclk);
        long_hold <= 1;
        repeat (2000) @(posedge aclk);
        long_hold <= 0;
    end

    function automatic logic [351:0] pack_stencil(int c, int l, int r, int d, int u,
                                                  int ur, int dr, int ul, int dl,
                                                  logic [30:0] w, logic [30:0] h);
        return {2'b0, h, w, dl, ul, dr, ur, u, d, r, l, c};
    endfunction

    task automatic send_word(logic [351:0] d);
        int g;
        g = no_idle ? 0 : $urandom_range(0, 8);
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (curv_pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // smooth stencil around a random centre, or raw random bits
    function automatic logic [351:0] random_stencil();
        int c, sp;
        int v[8];
        logic [30:0] w, h;
        if ($urandom_range(0, 9) < 3) begin
            return pack_stencil($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom,
                                31'($urandom), 31'($urandom));
        end
        sp = 1 << $urandom_range(4, 20);
        c = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        foreach (v[i]) v[i] = c + int'($urandom_range(0, 2 * sp)) - sp;
        w = 31'($urandom_range(1 << 10, 1 << 19));
        h = ($urandom_range(0, 1)) ? w : 31'($urandom_range(1 << 10, 1 << 19));
        return pack_stencil(c, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], w, h);
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed stencils under reset settings
        send_word(pack_stencil(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1, 31'd1));
        send_word(pack_stencil(65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536,
                               65536, 31'd65536, 31'd65536));
        send_word(pack_stencil(-65536, -65536, -65536, -65536, -65536, -65536, -65536,
                               -65536, -65536, 31'd65536, 31'd65536));
        send_word(pack_stencil(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                               32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                               32'sh7FFFFFFF, 31'd1, 31'd1));
        send_word(pack_stencil(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                               32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                               32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF));
        send_word(pack_stencil(0, -65536, 65536, -65536, 65536, 0, 0, 0, 0,
                               31'd65536, 31'd65536));
        send_word(pack_stencil(100, 0, 1, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
        send_word(pack_stencil(65536, 50000, 80000, 40000, 90000, 120000, 20000, 30000,
                               70000, 31'd65536, 31'd32768));
        send_word(pack_stencil(-2000, 1000, -5000, 3000, -7000, 9000, -4000, 2000, 6000,
                               31'd4096, 31'd8192));
        send_word(pack_stencil(0, 0, 131072, 0, 0, 65536, -65536, -65536, 65536,
                               31'd65536, 31'd65536));
        send_word(pack_stencil(1, 0, 0, -1, 1, 0, 0, 0, 0, 31'd1, 31'h7FFFFFFF));
        send_word(pack_stencil(32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1, 31'd1));
        for (int i = 0; i < 200; i++) send_word(random_stencil());
        wait_idle();

        // widest limit, no floor
        write_reg(CFG_MAX_CURVATURE, 31'h7FFFFFFF);
        write_reg(CFG_GRADIENT_FLOOR, 31'd0);
        for (int i = 0; i < 100; i++) send_word(random_stencil());
        // sender pause until every result is back
        s_tvalid <= 0;
        @(posedge aclk);
        while (curv_pending != 0) @(posedge aclk);
        for (int i = 0; i < 120; i++) send_word(random_stencil());
        wait_idle();

        // tightest limit, highest floor
        write_reg(CFG_MAX_CURVATURE, 31'd1);
        write_reg(CFG_GRADIENT_FLOOR, 31'h7FFFFFFF);
        no_idle = 1;
        for (int i = 0; i < 60; i++) send_word(random_stencil());
        no_idle = 0;
        for (int i = 0; i < 60; i++) send_word(random_stencil());
        wait_idle();

        // moderate settings, then random register values
        write_reg(CFG_MAX_CURVATURE, 31'd262144);
        write_reg(CFG_GRADIENT_FLOOR, 31'd65536);
        for (int i = 0; i < 150; i++) send_word(random_stencil());
        wait_idle();
        write_reg(CFG_MAX_CURVATURE, 31'($urandom_range(1, 32'h7FFFFFFF)));
        write_reg(CFG_GRADIENT_FLOOR, 31'($urandom_range(0, 1 << 17)));
        for (int i = 0; i < 150; i++) send_word(random_stencil());

        // drain
        s_tvalid <= 0;
        @(posedge aclk);
        while (curv_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
